// ===== hw/rtl/slot_list_move_to_front_table_assert.svh =====
// assertion macros for the slot list move-to-front table
`ifndef SLOT_LIST_MOVE_TO_FRONT_TABLE_ASSERT_SVH
`define SLOT_LIST_MOVE_TO_FRONT_TABLE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SLMTF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slmtf same-cycle check failed");

// antecedent implies consequent in the next cycle
`define SLMTF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slmtf next-cycle check failed");

`endif

// ===== hw/rtl/slmtf_pkg.sv =====
// shared constants and controller/datapath types for the slot list table
`timescale 1ns / 1ps

package slmtf_pkg;

    localparam int MAX_ENTRIES_DEF = 16;

    localparam int ACT_W  = 2;
    localparam int STAT_W = 2;
    localparam int TAG_W  = 32;

    localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FRONT  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_READ   = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_USED = 2'd2;

    typedef struct packed {
        logic init_wr;
        logic accept;
        logic ph0;
        logic ph1;
        logic finish;
    } slmtf_cmd_t;

    typedef struct packed {
        logic init_last;
    } slmtf_stat_t;

endpackage

// ===== hw/rtl/slmtf_ctrl.sv =====
// sequencer for init sweep, beat acceptance and link update phases
`timescale 1ns / 1ps

module slmtf_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    input  slmtf_pkg::slmtf_stat_t stat,
    output slmtf_pkg::slmtf_cmd_t  cmd
);

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_PH0  = 3'd2;
    localparam logic [2:0] S_PH1  = 3'd3;
    localparam logic [2:0] S_PH2  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next  = state_reg;
        cmd.init_wr = 1'b0;
        cmd.accept  = 1'b0;
        cmd.ph0     = 1'b0;
        cmd.ph1     = 1'b0;
        cmd.finish  = 1'b0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.init_wr = 1'b1;
                if (stat.init_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_PH0;
                end
            end
            S_PH0:
            begin
                cmd.ph0    = 1'b1;
                state_next = S_PH1;
            end
            S_PH1:
            begin
                cmd.ph1    = 1'b1;
                state_next = S_PH2;
            end
            S_PH2:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    assign out_valid_next = cmd.finish || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== hw/rtl/slmtf_dpath.sv =====
// link memories, list heads, op decode and result register
`timescale 1ns / 1ps

module slmtf_dpath
#(
    parameter int MAX_ENTRIES = slmtf_pkg::MAX_ENTRIES_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  slmtf_pkg::slmtf_cmd_t            cmd,
    output slmtf_pkg::slmtf_stat_t           stat,
    input  logic [slmtf_pkg::ACT_W-1:0]      action,
    input  logic [$clog2(MAX_ENTRIES)-1:0]   slot_index,
    input  logic [slmtf_pkg::TAG_W-1:0]      job_tag,
    output logic [slmtf_pkg::STAT_W-1:0]     status,
    output logic [$clog2(MAX_ENTRIES)-1:0]   slot,
    output logic [slmtf_pkg::TAG_W-1:0]      entry_tag,
    output logic [$clog2(MAX_ENTRIES+1)-1:0] entry_next,
    output logic [$clog2(MAX_ENTRIES+1)-1:0] alive_head,
    output logic                             has_free
);

    localparam int SLOT_W = $clog2(MAX_ENTRIES);
    localparam int LINK_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [LINK_W-1:0] NONE = LINK_W'(MAX_ENTRIES);
    localparam logic [SLOT_W-1:0] LAST = SLOT_W'(MAX_ENTRIES - 1);

    logic [LINK_W-1:0]           next_mem [MAX_ENTRIES];
    logic [LINK_W-1:0]           prev_mem [MAX_ENTRIES];
    logic [slmtf_pkg::TAG_W-1:0] tag_mem  [MAX_ENTRIES];
    logic                        used_mem [MAX_ENTRIES];

    logic [LINK_W-1:0]           fh_reg, fh_next;
    logic [LINK_W-1:0]           uh_reg, uh_next;
    logic [SLOT_W-1:0]           init_cnt_reg;

    logic [slmtf_pkg::ACT_W-1:0] act_reg;
    logic [SLOT_W-1:0]           idx_reg;
    logic [slmtf_pkg::TAG_W-1:0] tag_in_reg;
    logic                        rd_ok_reg;
    logic [LINK_W-1:0]           next_rd_reg;
    logic [LINK_W-1:0]           prev_rd_reg;
    logic [slmtf_pkg::TAG_W-1:0] tag_rd_reg;
    logic                        used_rd_reg;

    logic [SLOT_W-1:0]           rd_addr;
    logic                        rd_ok;

    logic                        is_add, is_remove, is_front, is_read;
    logic                        full, not_used, front_noop, do_wr, read_ok;
    logic [SLOT_W-1:0]           x_slot;
    logic [LINK_W-1:0]           tail_tgt;

    logic                        prev_we, next_we, used_we, tag_we;
    logic [SLOT_W-1:0]           prev_wa, next_wa, used_wa;
    logic [LINK_W-1:0]           prev_wd, next_wd;
    logic                        used_wd;

    logic [slmtf_pkg::STAT_W-1:0] status_next;
    logic [SLOT_W-1:0]            slot_next;

    assign stat.init_last = (init_cnt_reg == LAST);

    // read address: free head on add, addressed slot otherwise
    always_comb
    begin
        if (action == slmtf_pkg::ACT_ADD)
        begin
            rd_addr = fh_reg[SLOT_W-1:0];
            rd_ok   = (fh_reg != NONE);
        end
        else
        begin
            rd_addr = slot_index;
            rd_ok   = (LINK_W'(slot_index) < NONE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            act_reg    <= action;
            idx_reg    <= slot_index;
            tag_in_reg <= job_tag;
            rd_ok_reg  <= rd_ok;
        end
        if (cmd.accept && rd_ok)
        begin
            next_rd_reg <= next_mem[rd_addr];
            prev_rd_reg <= prev_mem[rd_addr];
            tag_rd_reg  <= tag_mem[rd_addr];
            used_rd_reg <= used_mem[rd_addr];
        end
    end

    assign is_add    = (act_reg == slmtf_pkg::ACT_ADD);
    assign is_remove = (act_reg == slmtf_pkg::ACT_REMOVE);
    assign is_front  = (act_reg == slmtf_pkg::ACT_FRONT);
    assign is_read   = (act_reg == slmtf_pkg::ACT_READ);

    assign full       = is_add && (fh_reg == NONE);
    assign not_used   = !is_add && !(rd_ok_reg && used_rd_reg);
    assign front_noop = is_front && (uh_reg == LINK_W'(idx_reg));
    assign do_wr      = !full && !not_used && !is_read && !front_noop;
    assign read_ok    = is_read && !not_used;

    assign x_slot   = is_add ? fh_reg[SLOT_W-1:0] : idx_reg;
    assign tail_tgt = is_remove ? fh_reg : uh_reg;

    // one write per memory per cycle: init sweep, then three link phases
    always_comb
    begin
        prev_we = 1'b0;
        prev_wa = x_slot;
        prev_wd = NONE;
        next_we = 1'b0;
        next_wa = x_slot;
        next_wd = NONE;
        used_we = 1'b0;
        used_wa = x_slot;
        used_wd = 1'b0;
        tag_we  = 1'b0;
        priority if (cmd.init_wr)
        begin
            prev_we = 1'b1;
            prev_wa = init_cnt_reg;
            prev_wd = (init_cnt_reg == '0) ? NONE
                                           : LINK_W'(init_cnt_reg) - LINK_W'(1);
            next_we = 1'b1;
            next_wa = init_cnt_reg;
            next_wd = LINK_W'(init_cnt_reg) + LINK_W'(1);
            used_we = 1'b1;
            used_wa = init_cnt_reg;
            used_wd = 1'b0;
        end
        else if (cmd.ph0 && do_wr)
        begin
            prev_we = 1'b1;
            prev_wd = NONE;
            next_we = 1'b1;
            next_wd = is_remove ? fh_reg : uh_reg;
            used_we = !is_front;
            used_wd = is_add;
            tag_we  = is_add;
        end
        else if (cmd.ph1 && do_wr)
        begin
            next_we = !is_add && (prev_rd_reg != NONE);
            next_wa = prev_rd_reg[SLOT_W-1:0];
            next_wd = next_rd_reg;
            prev_we = (next_rd_reg != NONE);
            prev_wa = next_rd_reg[SLOT_W-1:0];
            prev_wd = is_add ? NONE : prev_rd_reg;
        end
        else if (cmd.finish && do_wr)
        begin
            prev_we = (tail_tgt != NONE);
            prev_wa = tail_tgt[SLOT_W-1:0];
            prev_wd = LINK_W'(x_slot);
        end
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[prev_wa] <= prev_wd;
        end
        if (next_we)
        begin
            next_mem[next_wa] <= next_wd;
        end
        if (used_we)
        begin
            used_mem[used_wa] <= used_wd;
        end
        if (tag_we)
        begin
            tag_mem[x_slot] <= tag_in_reg;
        end
    end

    always_comb
    begin
        fh_next = fh_reg;
        uh_next = uh_reg;
        if (do_wr)
        begin
            priority if (is_add)
            begin
                fh_next = next_rd_reg;
                uh_next = LINK_W'(x_slot);
            end
            else if (is_remove)
            begin
                fh_next = LINK_W'(x_slot);
                if (prev_rd_reg == NONE)
                begin
                    uh_next = next_rd_reg;
                end
            end
            else
            begin
                uh_next = LINK_W'(x_slot);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fh_reg       <= '0;
            uh_reg       <= NONE;
            init_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.finish)
            begin
                fh_reg <= fh_next;
                uh_reg <= uh_next;
            end
            if (cmd.init_wr && !stat.init_last)
            begin
                init_cnt_reg <= init_cnt_reg + SLOT_W'(1);
            end
        end
    end

    always_comb
    begin
        priority if (full)
        begin
            status_next = slmtf_pkg::ST_FULL;
            slot_next   = '0;
        end
        else if (not_used)
        begin
            status_next = slmtf_pkg::ST_NOT_USED;
            slot_next   = idx_reg;
        end
        else
        begin
            status_next = slmtf_pkg::ST_OK;
            slot_next   = x_slot;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status     <= status_next;
            slot       <= slot_next;
            entry_tag  <= read_ok ? tag_rd_reg : '0;
            entry_next <= read_ok ? next_rd_reg : NONE;
            alive_head <= uh_next;
            has_free   <= (fh_next != NONE);
        end
    end

endmodule

// ===== hw/rtl/slot_list_move_to_front_table.sv =====
// slot list move-to-front table: one op at a time over linked slot memories
// result: registered when PH2 finishes after PH0 and PH1; PH2 waits on out_stall
// the single write port of the prev-link memory takes up to three prev-link
// updates per op; in_stall stays high until the op finishes
// reset: init sweep over all MAX_ENTRIES slots rebuilds the free list, in_stall high
`timescale 1ns / 1ps

`include "slot_list_move_to_front_table_assert.svh"

module slot_list_move_to_front_table
#(
    parameter int MAX_ENTRIES = slmtf_pkg::MAX_ENTRIES_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [slmtf_pkg::ACT_W-1:0]      action,
    input  logic [$clog2(MAX_ENTRIES)-1:0]   slot_index,
    input  logic [slmtf_pkg::TAG_W-1:0]      job_tag,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [slmtf_pkg::STAT_W-1:0]     status,
    output logic [$clog2(MAX_ENTRIES)-1:0]   slot,
    output logic [slmtf_pkg::TAG_W-1:0]      entry_tag,
    output logic [$clog2(MAX_ENTRIES+1)-1:0] entry_next,
    output logic [$clog2(MAX_ENTRIES+1)-1:0] alive_head,
    output logic                             has_free
);

    localparam int LINK_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [LINK_W-1:0] NONE = LINK_W'(MAX_ENTRIES);

    slmtf_pkg::slmtf_cmd_t  cmd;
    slmtf_pkg::slmtf_stat_t stat;

    slmtf_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    slmtf_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dpath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .action     (action),
        .slot_index (slot_index),
        .job_tag    (job_tag),
        .status     (status),
        .slot       (slot),
        .entry_tag  (entry_tag),
        .entry_next (entry_next),
        .alive_head (alive_head),
        .has_free   (has_free)
    );

    `SLMTF_ASSERT_NEXT(a_one_op_in_flight, clk, rst_n, in_valid && !in_stall, in_stall)
    `SLMTF_ASSERT_NEXT(a_finish_shows_result, clk, rst_n, cmd.finish, out_valid)
    `SLMTF_ASSERT_NOW(a_full_means_no_free, clk, rst_n,
        out_valid && (status == slmtf_pkg::ST_FULL), !has_free)
    `SLMTF_ASSERT_NOW(a_walk_needs_head, clk, rst_n,
        out_valid && (entry_next != NONE), alive_head != NONE)

endmodule

// ===== dv/tb_slot_list_move_to_front_table.sv =====
// self-checking testbench for the slot list move-to-front table
`timescale 1ns / 1ps

module tb_slot_list_move_to_front_table;

    localparam int SLOTS       = slmtf_pkg::MAX_ENTRIES_DEF;
    localparam int ACT_W       = slmtf_pkg::ACT_W;
    localparam int STAT_W      = slmtf_pkg::STAT_W;
    localparam int TAG_W       = slmtf_pkg::TAG_W;
    localparam int IDX_W       = $clog2(SLOTS);
    localparam int LNK_W       = $clog2(SLOTS + 1);
    localparam int RANDOM_OPS  = 900;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;
    localparam int DIR_ROWS    = 12;

    localparam logic [LNK_W-1:0] NONE = LNK_W'(SLOTS);

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  slot;
        logic [TAG_W-1:0]  entry_tag;
        logic [LNK_W-1:0]  entry_next;
        logic [LNK_W-1:0]  alive_head;
        logic              has_free;
    } reply_t;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic [IDX_W-1:0] idx;
        logic [TAG_W-1:0] tag;
        logic [4:0]       reps;
        logic             typed;
        reply_t           want;
    } stim_row_t;

    // rows with typed = 1 carry their expected reply, the rest go through the table model
    localparam stim_row_t DIRECTED [DIR_ROWS] = '{
        '{slmtf_pkg::ACT_READ,   4'd0,  32'h0,         5'd1,  1'b1,
          '{slmtf_pkg::ST_NOT_USED, 4'd0,  32'h0,         5'd16, 5'd16, 1'b1}},
        '{slmtf_pkg::ACT_FRONT,  4'd7,  32'h0,         5'd1,  1'b1,
          '{slmtf_pkg::ST_NOT_USED, 4'd7,  32'h0,         5'd16, 5'd16, 1'b1}},
        '{slmtf_pkg::ACT_ADD,    4'd15, 32'h0,         5'd1,  1'b1,
          '{slmtf_pkg::ST_OK,       4'd0,  32'h0,         5'd16, 5'd0,  1'b1}},
        '{slmtf_pkg::ACT_ADD,    4'd0,  32'hFFFF_FFFF, 5'd1,  1'b1,
          '{slmtf_pkg::ST_OK,       4'd1,  32'h0,         5'd16, 5'd1,  1'b1}},
        '{slmtf_pkg::ACT_READ,   4'd1,  32'h0,         5'd1,  1'b1,
          '{slmtf_pkg::ST_OK,       4'd1,  32'hFFFF_FFFF, 5'd0,  5'd1,  1'b1}},
        '{slmtf_pkg::ACT_FRONT,  4'd1,  32'h0,         5'd1,  1'b1,
          '{slmtf_pkg::ST_OK,       4'd1,  32'h0,         5'd16, 5'd1,  1'b1}},
        '{slmtf_pkg::ACT_FRONT,  4'd0,  32'h0,         5'd1,  1'b1,
          '{slmtf_pkg::ST_OK,       4'd0,  32'h0,         5'd16, 5'd0,  1'b1}},
        '{slmtf_pkg::ACT_REMOVE, 4'd1,  32'h0,         5'd1,  1'b1,
          '{slmtf_pkg::ST_OK,       4'd1,  32'h0,         5'd16, 5'd0,  1'b1}},
        '{slmtf_pkg::ACT_ADD,    4'd0,  32'hA5A5_0000, 5'd15, 1'b0,
          '{slmtf_pkg::ST_OK,       4'd0,  32'h0,         5'd16, 5'd0,  1'b0}},
        '{slmtf_pkg::ACT_ADD,    4'd9,  32'hFFFF_FFFF, 5'd1,  1'b1,
          '{slmtf_pkg::ST_FULL,     4'd0,  32'h0,         5'd16, 5'd15, 1'b0}},
        '{slmtf_pkg::ACT_REMOVE, 4'd15, 32'h0,         5'd1,  1'b1,
          '{slmtf_pkg::ST_OK,       4'd15, 32'h0,         5'd16, 5'd14, 1'b1}},
        '{slmtf_pkg::ACT_READ,   4'd0,  32'h0,         5'd1,  1'b1,
          '{slmtf_pkg::ST_OK,       4'd0,  32'h0,         5'd16, 5'd14, 1'b1}}
    };

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [ACT_W-1:0]  action;
    logic [IDX_W-1:0]  slot_index;
    logic [TAG_W-1:0]  job_tag;
    logic              out_valid;
    logic              out_stall;
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  slot;
    logic [TAG_W-1:0]  entry_tag;
    logic [LNK_W-1:0]  entry_next;
    logic [LNK_W-1:0]  alive_head;
    logic              has_free;

    logic [LNK_W-1:0] link_next [SLOTS];
    logic [LNK_W-1:0] link_prev [SLOTS];
    logic [TAG_W-1:0] tag_mem [SLOTS];
    logic             busy [SLOTS];
    logic [LNK_W-1:0] used_front;
    logic [LNK_W-1:0] free_front;
    int               used_count;

    reply_t pending_replies [$];

    int mismatches = 0;
    int beats_in   = 0;
    int beats_out  = 0;
    int n_add      = 0;
    int n_full     = 0;
    int n_remove   = 0;
    int n_front    = 0;
    int n_read     = 0;
    int n_miss     = 0;
    bit hold_req   = 1'b0;
    bit hold_done  = 1'b0;

    slot_list_move_to_front_table u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .slot_index (slot_index),
        .job_tag    (job_tag),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .slot       (slot),
        .entry_tag  (entry_tag),
        .entry_next (entry_next),
        .alive_head (alive_head),
        .has_free   (has_free)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic void clear_table();
        for (int i = 0; i < SLOTS; i++)
        begin
            link_next[i] = LNK_W'(i + 1);
            link_prev[i] = (i == 0) ? NONE : LNK_W'(i - 1);
            tag_mem[i]   = '0;
            busy[i]      = 1'b0;
        end
        used_front = NONE;
        free_front = '0;
        used_count = 0;
    endfunction

    function automatic void detach_used(logic [IDX_W-1:0] s);
        logic [LNK_W-1:0] p;
        logic [LNK_W-1:0] n;
        p = link_prev[s];
        n = link_next[s];
        if (p != NONE)
            link_next[p[IDX_W-1:0]] = n;
        else
            used_front = n;
        if (n != NONE)
            link_prev[n[IDX_W-1:0]] = p;
    endfunction

    function automatic void attach_used(logic [IDX_W-1:0] s);
        if (used_front != NONE)
            link_prev[used_front[IDX_W-1:0]] = LNK_W'(s);
        link_prev[s] = NONE;
        link_next[s] = used_front;
        used_front   = LNK_W'(s);
    endfunction

    function automatic reply_t apply_table_op(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx,
                                              logic [TAG_W-1:0] tag);
        reply_t           r;
        logic [IDX_W-1:0] s;
        r.status     = slmtf_pkg::ST_OK;
        r.slot       = idx;
        r.entry_tag  = '0;
        r.entry_next = NONE;
        if (act == slmtf_pkg::ACT_ADD)
        begin
            if (free_front == NONE)
            begin
                r.status = slmtf_pkg::ST_FULL;
                r.slot   = '0;
            end
            else
            begin
                s          = free_front[IDX_W-1:0];
                free_front = link_next[s];
                if (free_front != NONE)
                    link_prev[free_front[IDX_W-1:0]] = NONE;
                tag_mem[s] = tag;
                busy[s]    = 1'b1;
                used_count++;
                attach_used(s);
                r.slot = s;
            end
        end
        else if (!busy[idx])
            r.status = slmtf_pkg::ST_NOT_USED;
        else if (act == slmtf_pkg::ACT_REMOVE)
        begin
            detach_used(idx);
            if (free_front != NONE)
                link_prev[free_front[IDX_W-1:0]] = LNK_W'(idx);
            link_prev[idx] = NONE;
            link_next[idx] = free_front;
            free_front     = LNK_W'(idx);
            busy[idx]      = 1'b0;
            used_count--;
        end
        else if (act == slmtf_pkg::ACT_FRONT)
        begin
            if (used_front != LNK_W'(idx))
            begin
                detach_used(idx);
                attach_used(idx);
            end
        end
        else
        begin
            r.entry_tag  = tag_mem[idx];
            r.entry_next = link_next[idx];
        end
        r.alive_head = used_front;
        r.has_free   = (free_front != NONE);
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] pick_used_slot();
        logic [LNK_W-1:0] s;
        int               k;
        s = used_front;
        k = $urandom_range(0, used_count - 1);
        repeat (k)
            s = link_next[s[IDX_W-1:0]];
        return IDX_W'(s);
    endfunction

    task automatic report_mismatch(string what, logic [TAG_W-1:0] seen, logic [TAG_W-1:0] want);
        $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $time, what, seen, want);
        mismatches++;
    endtask

    task automatic send_beat(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx, logic [TAG_W-1:0] tag,
                             bit typed, reply_t want);
        reply_t model;
        @(negedge clk);
        in_valid   <= 1'b1;
        action     <= act;
        slot_index <= idx;
        job_tag    <= tag;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        model = apply_table_op(act, idx, tag);
        pending_replies.push_back(typed ? want : model);
        beats_in++;
        if (model.status == slmtf_pkg::ST_FULL)
            n_full++;
        else if (model.status == slmtf_pkg::ST_NOT_USED)
            n_miss++;
        else if (act == slmtf_pkg::ACT_ADD)
            n_add++;
        else if (act == slmtf_pkg::ACT_REMOVE)
            n_remove++;
        else if (act == slmtf_pkg::ACT_FRONT)
            n_front++;
        else
            n_read++;
    endtask

    task automatic idle_gap(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            in_valid   <= 1'b0;
            action     <= ACT_W'($urandom);
            slot_index <= IDX_W'($urandom);
            job_tag    <= $urandom;
        end
    endtask

    task automatic walk_used_list();
        logic [LNK_W-1:0] s;
        s = used_front;
        while (s != NONE)
        begin
            send_beat(slmtf_pkg::ACT_READ, IDX_W'(s), $urandom, 1'b0, '0);
            s = link_next[s[IDX_W-1:0]];
        end
    endtask

    // receiver stall pattern, with one long hold-off to back the block up
    initial
    begin
        int mode;
        int left;
        int phase;
        out_stall = 1'b0;
        mode      = 0;
        left      = 0;
        phase     = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1)
                    @(negedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(20, 80);
                end
                left--;
                phase++;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 2) == 0);
                    2: out_stall <= phase[0];
                    default: out_stall <= (phase % 4 != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        reply_t w;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            beats_out++;
            if (pending_replies.size() == 0)
                report_mismatch("result with nothing pending", TAG_W'(slot), '0);
            else
            begin
                w = pending_replies.pop_front();
                if (status !== w.status)
                    report_mismatch("status", TAG_W'(status), TAG_W'(w.status));
                if (slot !== w.slot)
                    report_mismatch("slot", TAG_W'(slot), TAG_W'(w.slot));
                if (entry_tag !== w.entry_tag)
                    report_mismatch("entry_tag", entry_tag, w.entry_tag);
                if (entry_next !== w.entry_next)
                    report_mismatch("entry_next", TAG_W'(entry_next), TAG_W'(w.entry_next));
                if (alive_head !== w.alive_head)
                    report_mismatch("alive_head", TAG_W'(alive_head), TAG_W'(w.alive_head));
                if (has_free !== w.has_free)
                    report_mismatch("has_free", TAG_W'(has_free), TAG_W'(w.has_free));
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("no beat moved for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, pending_replies.size());
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        logic [ACT_W-1:0] act;
        logic [IDX_W-1:0] idx;
        int               left_ops;
        int               burst;
        int               mode_left;
        int               fill_mode;
        int               pick;
        int               walk_len;
        int               add_pct [3];
        int               rm_pct [3];
        int               fr_pct [3];

        // grow, shrink and churn mixes
        add_pct = '{55, 15, 30};
        rm_pct  = '{65, 55, 55};
        fr_pct  = '{80, 75, 75};

        clear_table();
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        action     = slmtf_pkg::ACT_ADD;
        slot_index = '0;
        job_tag    = '0;
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            for (int k = 0; k < int'(DIRECTED[i].reps); k++)
                send_beat(DIRECTED[i].act, DIRECTED[i].idx, DIRECTED[i].tag + TAG_W'(k),
                          DIRECTED[i].typed, DIRECTED[i].want);

        left_ops  = RANDOM_OPS;
        burst     = 0;
        mode_left = 0;
        fill_mode = 0;
        while (left_ops > 0)
        begin
            if (!hold_req && left_ops <= RANDOM_OPS - 100)
                hold_req = 1'b1;
            if (burst == 0)
            begin
                burst = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                    : $urandom_range(1, 12);
                if ($urandom_range(0, 3) != 0)
                    idle_gap($urandom_range(1, 6));
            end
            if (mode_left == 0)
            begin
                fill_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(30, 90);
            end
            pick = $urandom_range(0, 99);
            if (pick < 4 && used_count > 0)
            begin
                walk_len = used_count;
                walk_used_list();
                left_ops -= walk_len;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < add_pct[fill_mode])
                    act = slmtf_pkg::ACT_ADD;
                else if (pick < rm_pct[fill_mode])
                    act = slmtf_pkg::ACT_REMOVE;
                else if (pick < fr_pct[fill_mode])
                    act = slmtf_pkg::ACT_FRONT;
                else
                    act = slmtf_pkg::ACT_READ;
                if (used_count > 0 && $urandom_range(0, 9) < 8)
                    idx = pick_used_slot();
                else
                    idx = IDX_W'($urandom);
                send_beat(act, idx, $urandom, 1'b0, '0);
                left_ops--;
            end
            burst--;
            mode_left--;
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);

        $display("%0d ops sent, %0d results checked: %0d adds, %0d adds on a full table",
                 beats_in, beats_out, n_add, n_full);
        $display("%0d removes, %0d moves to front, %0d reads, %0d ops on a free slot",
                 n_remove, n_front, n_read, n_miss);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== slot_list_move_to_front_table.f =====
+incdir+hw/rtl
hw/rtl/slmtf_pkg.sv
hw/rtl/slmtf_ctrl.sv
hw/rtl/slmtf_dpath.sv
hw/rtl/slot_list_move_to_front_table.sv
dv/tb_slot_list_move_to_front_table.sv
